/* sv/andt_pkg.sv */
`default_nettype none

package andt_pkg;

  // Fixed field widths of the command and result beats.
  localparam int MODE_W    = 3;
  localparam int ID_W      = 16;
  localparam int DIST_W    = 16;
  localparam int IN_TIME_W = 32;
  localparam int SLOT_IN_W = 4;
  localparam int CNT_OUT_W = 5;
  localparam int AGE_W     = 31;

  // Operation codes carried on the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_UPDATE = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_LOOKUP = 3'd2,
    MODE_PRUNE  = 3'd3,
    MODE_CLEAR  = 3'd4,
    MODE_READ   = 3'd5
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic write;
    logic read;
    logic report;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_scan;
    logic go_read;
    logic is_update;
    logic scan_end;
  } status_t;

endpackage

`default_nettype wire

/* sv/andt_ram.sv */
`default_nettype none

module andt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/andt_ctrl.sv */
`default_nettype none

module andt_ctrl
  import andt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t st,
  output cmd_t         cmd,
  output logic         busy
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_WRITE  = 5'b00100,
    S_READ   = 5'b01000,
    S_REPORT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing: scan the table or read a slot, write back an update, then report.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (st.go_scan) begin
            state_next = S_SCAN;
          end else if (st.go_read) begin
            state_next = S_READ;
          end else begin
            state_next = S_REPORT;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_end) begin
          state_next = st.is_update ? S_WRITE : S_REPORT;
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_REPORT;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

/* sv/andt_datapath.sv */
`default_nettype none

module andt_datapath
  import andt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output status_t                   st,
  input  wire logic [MODE_W-1:0]    mode,
  input  wire logic [ID_W-1:0]      node_id,
  input  wire logic [DIST_W-1:0]    distance_mm,
  input  wire logic [IN_TIME_W-1:0] now_time,
  input  wire logic [SLOT_IN_W-1:0] slot_index,
  input  wire logic                 cfg_we,
  input  wire logic [AGE_W-1:0]     cfg_wdata,
  output logic                      done,
  output logic                      hit,
  output logic [DIST_W-1:0]         out_distance,
  output logic [ID_W-1:0]           out_node,
  output logic [IN_TIME_W-1:0]      last_seen,
  output logic [CNT_OUT_W-1:0]      entry_count,
  output logic                      dropped,
  output logic [CNT_OUT_W-1:0]      pruned_count
);

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int WORD_W = ID_W + DIST_W + TIME_WIDTH;
  localparam int CMP_W  = (TIME_WIDTH > AGE_W) ? TIME_WIDTH : AGE_W;

  // Latched command beat and the age limit register.
  logic [MODE_W-1:0]     mode_r;
  logic [ID_W-1:0]       id_r;
  logic [DIST_W-1:0]     dist_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [SLOT_IN_W-1:0]  slot_r;
  logic [AGE_W-1:0]      age_limit;

  // Per-slot flags and occupancy.
  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] written;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       pruned;

  // Scan pipeline: address issue, then compare in the next cycle.
  logic [CNT_W-1:0]  scan_idx;
  logic [SLOT_W-1:0] cmp_idx;
  logic              cmp_live;
  logic              matched;
  logic [SLOT_W-1:0] hit_idx;
  logic [DIST_W-1:0] hit_dist;
  logic [TIME_WIDTH-1:0] hit_time;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;

  // Entry memory port signals.
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [ID_W-1:0]       rd_id;
  logic [DIST_W-1:0]     rd_dist;
  logic [TIME_WIDTH-1:0] rd_time;
  logic                  is_search;
  logic                  issue;
  logic                  cmp_on;
  logic                  entry_vld;
  logic                  match;
  logic [TIME_WIDTH-1:0] age;
  logic                  aged;
  logic                  prune_hit;
  logic                  last_cmp;
  logic [SLOT_W-1:0]     slot_addr;
  logic                  slot_ok;
  logic                  ins;
  logic                  upd;

  logic                  hit_n;
  logic [DIST_W-1:0]     dist_n;
  logic [ID_W-1:0]       node_n;
  logic [TIME_WIDTH-1:0] time_n;
  logic                  drop_n;
  logic [CNT_W-1:0]      prn_n;

  andt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_id   = ram_rdata[0 +: ID_W];
  assign rd_dist = ram_rdata[ID_W +: DIST_W];
  assign rd_time = ram_rdata[ID_W + DIST_W +: TIME_WIDTH];

  // Compare stage: id match on valid slots, first free slot, aging.
  assign is_search = (mode_r == MODE_UPDATE) || (mode_r == MODE_REMOVE) ||
                     (mode_r == MODE_LOOKUP);
  assign issue     = cmd.scan && (scan_idx < CNT_W'(TABLE_DEPTH));
  assign cmp_on    = cmd.scan && cmp_live;
  assign entry_vld = valid[cmp_idx];
  assign match     = cmp_on && is_search && entry_vld && (rd_id == id_r);
  assign age       = now_r - rd_time;
  assign aged      = !age[TIME_WIDTH-1] && (CMP_W'(age) > CMP_W'(age_limit));
  assign prune_hit = cmp_on && (mode_r == MODE_PRUNE) && entry_vld && aged;
  assign last_cmp  = (cmp_idx == SLOT_W'(TABLE_DEPTH - 1));

  // Slot read and memory addressing.
  assign slot_addr = SLOT_W'(slot_r);
  assign slot_ok   = (32'(slot_r) < 32'(TABLE_DEPTH));
  assign ram_re    = issue || cmd.read;
  assign ram_raddr = cmd.read ? slot_addr : scan_idx[SLOT_W-1:0];

  // Write-back of an update: refresh a matched slot when the distance is nonzero, or insert into the first free slot.
  assign ins       = cmd.write && (mode_r == MODE_UPDATE) && !matched && free_found;
  assign upd       = cmd.write && (mode_r == MODE_UPDATE) && matched &&
                     (dist_r != '0);
  assign ram_we    = ins || upd;
  assign ram_waddr = matched ? hit_idx : free_idx;
  assign ram_wdata = {now_r, dist_r, id_r};

  // Status toward the controller.
  always_comb begin
    st.go_scan   = (mode == MODE_UPDATE) || (mode == MODE_REMOVE) ||
                   (mode == MODE_LOOKUP) || (mode == MODE_PRUNE);
    st.go_read   = (mode == MODE_READ);
    st.is_update = (mode_r == MODE_UPDATE);
    st.scan_end  = cmp_on && (match || last_cmp);
  end

  // Control state: flags, count, config and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      written   <= '0;
      count     <= '0;
      age_limit <= '0;
      cmp_live  <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (cfg_we) begin
        age_limit <= cfg_wdata;
      end
      if (cmd.load && (mode == MODE_CLEAR)) begin
        valid   <= '0;
        written <= '0;
        count   <= '0;
      end
      if ((match && (mode_r == MODE_REMOVE)) || prune_hit) begin
        valid[cmp_idx] <= 1'b0;
        count          <= count - CNT_W'(1);
      end
      if (ins) begin
        valid[free_idx]   <= 1'b1;
        written[free_idx] <= 1'b1;
        count             <= count + CNT_W'(1);
      end
      cmp_live <= issue;
      done     <= cmd.report;
    end
  end

  // Result fields for the reported slot.
  always_comb begin
    hit_n  = 1'b0;
    dist_n = '0;
    node_n = '0;
    time_n = '0;
    drop_n = 1'b0;
    prn_n  = '0;
    case (mode_r)
      MODE_UPDATE: begin
        if (matched) begin
          hit_n  = 1'b1;
          node_n = id_r;
          if (dist_r != '0) begin
            dist_n = dist_r;
            time_n = now_r;
          end else begin
            dist_n = hit_dist;
            time_n = hit_time;
          end
        end else if (free_found) begin
          node_n = id_r;
          dist_n = dist_r;
          time_n = now_r;
        end else begin
          drop_n = 1'b1;
        end
      end
      MODE_REMOVE, MODE_LOOKUP: begin
        if (matched) begin
          hit_n  = 1'b1;
          node_n = id_r;
          dist_n = hit_dist;
          time_n = hit_time;
        end
      end
      MODE_PRUNE: begin
        prn_n = pruned;
      end
      MODE_READ: begin
        if (slot_ok) begin
          hit_n = valid[slot_addr];
          if (written[slot_addr]) begin
            node_n = rd_id;
            dist_n = rd_dist;
            time_n = rd_time;
          end
        end
      end
      default: begin
        prn_n = '0;
      end
    endcase
  end

  // Payload registers: command latch, scan tracking and result beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= mode;
      id_r       <= node_id;
      dist_r     <= distance_mm;
      now_r      <= TIME_WIDTH'(now_time);
      slot_r     <= slot_index;
      scan_idx   <= '0;
      matched    <= 1'b0;
      free_found <= 1'b0;
      pruned     <= '0;
    end
    if (issue) begin
      scan_idx <= scan_idx + CNT_W'(1);
      cmp_idx  <= scan_idx[SLOT_W-1:0];
    end
    if (match) begin
      matched  <= 1'b1;
      hit_idx  <= cmp_idx;
      hit_dist <= rd_dist;
      hit_time <= rd_time;
    end
    if (cmp_on && !entry_vld && !free_found) begin
      free_found <= 1'b1;
      free_idx   <= cmp_idx;
    end
    if (prune_hit) begin
      pruned <= pruned + CNT_W'(1);
    end
    if (cmd.report) begin
      hit          <= hit_n;
      out_distance <= dist_n;
      out_node     <= node_n;
      last_seen    <= IN_TIME_W'(time_n);
      entry_count  <= CNT_OUT_W'(count);
      dropped      <= drop_n;
      pruned_count <= CNT_OUT_W'(prn_n);
    end
  end

endmodule

`default_nettype wire

/* sv/aging_neighbor_distance_table_core.sv */
`default_nettype none

// Neighbor table with age pruning. A command beat is taken when start is high
// and busy is low; its single result beat appears on the result ports for
// exactly one cycle with done high, and the receiver cannot stall it. Entries
// live in one RAM with a single registered read port, so the search for an id,
// the search for a free slot and the prune pass visit one slot per cycle.
// Clear and unused modes go from accept straight to the report; read slot
// reads its slot first; lookup and remove scan until a slot matches or the
// last slot is compared, prune scans the whole table, and update scans like
// lookup, then a write-back step. A new command may be taken in the cycle in
// which done is high. The table is empty after reset and needs no clearing pass.
module aging_neighbor_distance_table_core
  import andt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [MODE_W-1:0]    mode,
  input  wire logic [ID_W-1:0]      node_id,
  input  wire logic [DIST_W-1:0]    distance_mm,
  input  wire logic [IN_TIME_W-1:0] now_time,
  input  wire logic [SLOT_IN_W-1:0] slot_index,
  output logic                      done,
  output logic                      hit,
  output logic [DIST_W-1:0]         out_distance,
  output logic [ID_W-1:0]           out_node,
  output logic [IN_TIME_W-1:0]      last_seen,
  output logic [CNT_OUT_W-1:0]      entry_count,
  output logic                      dropped,
  output logic [CNT_OUT_W-1:0]      pruned_count,
  input  wire logic                 cfg_we,
  input  wire logic [AGE_W-1:0]     cfg_wdata
);

  cmd_t    cmd;
  status_t st;

  // Sequencer.
  andt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .st   (st),
    .cmd  (cmd),
    .busy (busy)
  );

  // Table storage, compare logic and result registers.
  andt_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .mode        (mode),
    .node_id     (node_id),
    .distance_mm (distance_mm),
    .now_time    (now_time),
    .slot_index  (slot_index),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .hit         (hit),
    .out_distance(out_distance),
    .out_node    (out_node),
    .last_seen   (last_seen),
    .entry_count (entry_count),
    .dropped     (dropped),
    .pruned_count(pruned_count)
  );

endmodule

`default_nettype wire

/* sv/andt_checker.sv */
`default_nettype none

module andt_checker
  import andt_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 done,
  input wire logic                 hit,
  input wire logic                 dropped,
  input wire logic [CNT_OUT_W-1:0] pruned_count,
  input wire logic [ID_W-1:0]      out_node
);

  // A result beat only shows once the command has finished.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // An accepted command always occupies the block.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // Every finished command delivers exactly at its end.
  a_end_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("command ended without a result beat");

  // A dropped insert reports no slot.
  a_drop_empty: assert property (@(posedge clk) disable iff (rst)
    (done && dropped) |-> (!hit && (out_node == '0) && (pruned_count == '0)))
    else $error("dropped update reported slot contents");

  // A prune result carries no hit or drop.
  a_prune_only: assert property (@(posedge clk) disable iff (rst)
    (done && (pruned_count != '0)) |-> (!hit && !dropped))
    else $error("prune result mixed with hit or drop");

endmodule

bind aging_neighbor_distance_table_core andt_checker u_andt_checker (.*);

`default_nettype wire
